@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each expects signals named clock and reset
// in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VFV_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("voxel face visibility: check failed");

// Consequent must hold in the cycle after the antecedent.
`define VFV_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("voxel face visibility: check failed");

`endif

@@ src/vfv_pkg.sv @@
`default_nettype none

package vfv_pkg;

   // Fixed field widths of the request and response transactions
   localparam int unsigned COORD_W    = 4;
   localparam int unsigned SIDE_W     = 3;
   localparam int unsigned FACE_W     = 6;
   localparam int unsigned COUNT_W    = 3;
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned STEP_W     = 3;

   // Bit positions inside req_tdata
   localparam int unsigned REQ_X_LSB     = 0;
   localparam int unsigned REQ_Y_LSB     = 4;
   localparam int unsigned REQ_Z_LSB     = 8;
   localparam int unsigned REQ_SIDE_LSB  = 12;
   localparam int unsigned REQ_A_LSB     = 15;
   localparam int unsigned REQ_B_LSB     = 19;
   localparam int unsigned REQ_SOLID_BIT = 23;

   // Face / side codes, shared by boundary writes and the face mask
   localparam logic [SIDE_W-1:0] DIR_PX     = 3'd0;
   localparam logic [SIDE_W-1:0] DIR_NX     = 3'd1;
   localparam logic [SIDE_W-1:0] DIR_PY     = 3'd2;
   localparam logic [SIDE_W-1:0] DIR_NY     = 3'd3;
   localparam logic [SIDE_W-1:0] DIR_PZ     = 3'd4;
   localparam logic [SIDE_W-1:0] DIR_NZ     = 3'd5;
   localparam logic [SIDE_W-1:0] SIDE_COUNT = 3'd6;

   // Last scan step: step 0 reads the center cell, steps 1..6 the neighbors
   localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
   localparam logic [STEP_W-1:0] STEP_FINAL  = 3'd6;

   typedef enum logic [CMD_W-1:0] {
      CMD_WR_CELL  = 2'd0,
      CMD_WR_BOUND = 2'd1,
      CMD_QUERY    = 2'd2,
      CMD_NOP      = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_LAST = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // Where the bit read in a scan step comes from
   typedef enum logic [1:0] {
      RD_CHUNK = 2'd0,
      RD_BOUND = 2'd1,
      RD_HIDE  = 2'd2
   } rd_kind_type;

   function automatic logic [COUNT_W-1:0] face_popcount(input logic [FACE_W-1:0] mask);
      logic [COUNT_W-1:0] cnt;
      cnt = '0;
      for (int i = 0; i < FACE_W; i++) begin
         cnt = cnt + COUNT_W'(mask[i]);
      end
      return cnt;
   endfunction

endpackage

`default_nettype wire

@@ src/vfv_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module vfv_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ src/voxel_face_visibility_core.sv @@
`default_nettype none

// Channel   Ports                              Carries
// req       req_tvalid/tready/tdata/tuser      command in tuser; cell, side, plane, solid
// rsp       rsp_tvalid/tready/tdata            visible faces and face count
// csr       csr_valid/ready/data               neighbor_present register
//
// A write passes through ST_DONE before the next accept; a query is paced by
// the single read port of the chunk memory: seven reads (center, six neighbors)
// issue one per cycle in ST_SCAN, then ST_LAST drains and ST_DONE responds.
// Reset is synchronous and clears control state and neighbor_present only.
// A result waiting in rsp does not block the next accept; a new result waits
// in ST_DONE until the output register frees.
`include "assert_macros.svh"

module voxel_face_visibility_core
   import vfv_pkg::*;
#(
   parameter int unsigned EDGE = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tdata: cell_x[3:0], cell_y[7:4], cell_z[11:8], side[14:12],
   //        plane_a[18:15], plane_b[22:19], solid[23]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: command[1:0]
   input  wire logic [CMD_W-1:0]      req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: visible_faces[5:0], face_count[8:6], zero[15:9]
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [FACE_W-1:0]     csr_data
);

   localparam int unsigned EDGE_W  = $clog2(EDGE + 1);
   localparam int unsigned CW      = (EDGE_W > COORD_W) ? EDGE_W : COORD_W;
   localparam int unsigned CELLS   = EDGE * EDGE * EDGE;
   localparam int unsigned BCELLS  = 6 * EDGE * EDGE;
   localparam int unsigned CAW     = $clog2(CELLS);
   localparam int unsigned BAW     = $clog2(BCELLS);
   localparam logic [CW-1:0] LIM   = CW'(EDGE);

   function automatic logic [CAW-1:0] cell_addr(input logic [CW-1:0] cx,
                                                input logic [CW-1:0] cy,
                                                input logic [CW-1:0] cz);
      return (CAW'(cx) * CAW'(EDGE) + CAW'(cy)) * CAW'(EDGE) + CAW'(cz);
   endfunction

   function automatic logic [BAW-1:0] bound_addr(input logic [SIDE_W-1:0] s,
                                                 input logic [CW-1:0]     pa,
                                                 input logic [CW-1:0]     pb);
      return (BAW'(s) * BAW'(EDGE) + BAW'(pa)) * BAW'(EDGE) + BAW'(pb);
   endfunction

   // Control and payload registers
   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [STEP_W-1:0]     cap_step_ff, cap_step_in;
   rd_kind_type           cap_kind_ff, cap_kind_in;
   logic [CW-1:0]         qx_ff, qy_ff, qz_ff;
   logic [FACE_W-1:0]     mask_ff;
   logic                  center_ff;
   logic [FACE_W-1:0]     present_ff;
   logic                  rsp_valid_ff;
   logic [FACE_W-1:0]     rsp_faces_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   // Request decode
   cmd_type               cmd;
   logic [CW-1:0]         req_x, req_y, req_z, req_a, req_b;
   logic [SIDE_W-1:0]     req_side;
   logic                  req_solid;
   logic                  req_acc;
   logic                  coords_ok;
   logic                  plane_ok;
   logic                  rsp_free;

   // Memory ports
   logic                  chunk_we, bound_we, mem_re;
   logic [CAW-1:0]        chunk_waddr, chunk_raddr;
   logic [BAW-1:0]        bound_waddr, bound_raddr;
   logic                  chunk_rdata, bound_rdata;
   logic                  rd_bit;
   logic [SIDE_W-1:0]     scan_dir;
   logic                  at_edge;
   logic [FACE_W-1:0]     final_mask;

   assign cmd       = cmd_type'(req_tuser);
   assign req_x     = CW'(req_tdata[REQ_X_LSB +: COORD_W]);
   assign req_y     = CW'(req_tdata[REQ_Y_LSB +: COORD_W]);
   assign req_z     = CW'(req_tdata[REQ_Z_LSB +: COORD_W]);
   assign req_side  = req_tdata[REQ_SIDE_LSB +: SIDE_W];
   assign req_a     = CW'(req_tdata[REQ_A_LSB +: COORD_W]);
   assign req_b     = CW'(req_tdata[REQ_B_LSB +: COORD_W]);
   assign req_solid = req_tdata[REQ_SOLID_BIT];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign coords_ok  = (req_x < LIM) && (req_y < LIM) && (req_z < LIM);
   assign plane_ok   = (req_side < SIDE_COUNT) && (req_a < LIM) && (req_b < LIM);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // Writes go straight into the memories on accept
   assign chunk_we    = req_acc && (cmd == CMD_WR_CELL) && coords_ok;
   assign bound_we    = req_acc && (cmd == CMD_WR_BOUND) && plane_ok;
   assign chunk_waddr = cell_addr(req_x, req_y, req_z);
   assign bound_waddr = bound_addr(req_side, req_a, req_b);
   assign mem_re      = (state_ff == ST_SCAN);

   // Read address and source for the current scan step
   assign scan_dir = step_ff - STEP_W'(1);
   always_comb begin
      chunk_raddr = cell_addr(qx_ff, qy_ff, qz_ff);
      bound_raddr = bound_addr(DIR_PX, qy_ff, qz_ff);
      at_edge     = 1'b0;
      if (step_ff != STEP_CENTER) begin
         unique case (scan_dir)
            DIR_PX: begin
               at_edge     = CW'(qx_ff + CW'(1)) >= LIM;
               chunk_raddr = cell_addr(CW'(qx_ff + CW'(1)), qy_ff, qz_ff);
               bound_raddr = bound_addr(DIR_PX, qy_ff, qz_ff);
            end
            DIR_NX: begin
               at_edge     = (qx_ff == '0);
               chunk_raddr = cell_addr(CW'(qx_ff - CW'(1)), qy_ff, qz_ff);
               bound_raddr = bound_addr(DIR_NX, qy_ff, qz_ff);
            end
            DIR_PY: begin
               at_edge     = CW'(qy_ff + CW'(1)) >= LIM;
               chunk_raddr = cell_addr(qx_ff, CW'(qy_ff + CW'(1)), qz_ff);
               bound_raddr = bound_addr(DIR_PY, qx_ff, qz_ff);
            end
            DIR_NY: begin
               at_edge     = (qy_ff == '0);
               chunk_raddr = cell_addr(qx_ff, CW'(qy_ff - CW'(1)), qz_ff);
               bound_raddr = bound_addr(DIR_NY, qx_ff, qz_ff);
            end
            DIR_PZ: begin
               at_edge     = CW'(qz_ff + CW'(1)) >= LIM;
               chunk_raddr = cell_addr(qx_ff, qy_ff, CW'(qz_ff + CW'(1)));
               bound_raddr = bound_addr(DIR_PZ, qx_ff, qy_ff);
            end
            DIR_NZ: begin
               at_edge     = (qz_ff == '0);
               chunk_raddr = cell_addr(qx_ff, qy_ff, CW'(qz_ff - CW'(1)));
               bound_raddr = bound_addr(DIR_NZ, qx_ff, qy_ff);
            end
            default: begin
               at_edge = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      if (step_ff == STEP_CENTER || !at_edge) begin
         cap_kind_in = RD_CHUNK;
      end else if (present_ff[scan_dir]) begin
         cap_kind_in = RD_BOUND;
      end else begin
         cap_kind_in = RD_HIDE;
      end
      cap_step_in = step_ff;
   end

   vfv_ram #(
      .WIDTH (1),
      .DEPTH (CELLS)
   ) u_chunk_ram (
      .clock   (clock),
      .wr_en   (chunk_we),
      .wr_addr (chunk_waddr),
      .wr_data (req_solid),
      .rd_en   (mem_re),
      .rd_addr (chunk_raddr),
      .rd_data (chunk_rdata)
   );

   vfv_ram #(
      .WIDTH (1),
      .DEPTH (BCELLS)
   ) u_bound_ram (
      .clock   (clock),
      .wr_en   (bound_we),
      .wr_addr (bound_waddr),
      .wr_data (req_solid),
      .rd_en   (mem_re),
      .rd_addr (bound_raddr),
      .rd_data (bound_rdata)
   );

   assign rd_bit     = (cap_kind_ff == RD_BOUND) ? bound_rdata : chunk_rdata;
   assign final_mask = mask_ff & {FACE_W{center_ff}};

   // Sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = STEP_CENTER;
            if (req_acc) begin
               state_in = (cmd == CMD_QUERY && coords_ok) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_FINAL) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_CENTER;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_valid && csr_ready) begin
            present_ff <= csr_data;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Query payload: latch coordinates, collect center and face bits
   always_ff @(posedge clock) begin
      cap_step_ff <= cap_step_in;
      cap_kind_ff <= cap_kind_in;
      if (req_acc) begin
         qx_ff     <= req_x;
         qy_ff     <= req_y;
         qz_ff     <= req_z;
         mask_ff   <= '0;
         center_ff <= 1'b0;
      end else if ((state_ff == ST_SCAN && step_ff != STEP_CENTER) ||
                   state_ff == ST_LAST) begin
         if (cap_step_ff == STEP_CENTER) begin
            center_ff <= rd_bit;
         end else begin
            mask_ff[cap_step_ff - STEP_W'(1)] <= (cap_kind_ff != RD_HIDE) && !rd_bit;
         end
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_faces_ff <= final_mask;
         rsp_count_ff <= face_popcount(final_mask);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - FACE_W - COUNT_W)'(0), rsp_count_ff, rsp_faces_ff};

   `VFV_ASSERT_SAME(a_count_matches, rsp_valid_ff, rsp_count_ff == $countones(rsp_faces_ff))
   `VFV_ASSERT_SAME(a_no_write_in_scan, state_ff == ST_SCAN, !chunk_we && !bound_we)
   `VFV_ASSERT_SAME(a_step_bound, state_ff == ST_SCAN, step_ff <= STEP_FINAL)
   `VFV_ASSERT_NEXT(a_done_delivers, state_ff == ST_DONE && rsp_free,
                    rsp_valid_ff && state_ff == ST_IDLE)

endmodule

`default_nettype wire
